### design/sphere_to_uv_map_core_assert.svh
// Assertion macros used by the checker file s2uv_checker.
`ifndef SPHERE_TO_UV_MAP_CORE_ASSERT_SVH
`define SPHERE_TO_UV_MAP_CORE_ASSERT_SVH
// Same-cycle implication, sampled on clk, off during rst.
`define S2UV_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication, sampled on clk, off during rst.
`define S2UV_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
// Same-cycle implication that is checked during reset as well.
`define S2UV_ASSERT_ALWAYS(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |-> (post)) else $error(msg);
`endif

### design/s2uv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2uv_pkg
// Types, constants and step functions for the sphere to UV mapping pipeline.
// ----------------------------------------------------------------------------
package s2uv_pkg;

  localparam int RadiusW   = 23;
  localparam int CoordW    = 24;
  localparam int UW        = 16;
  localparam int VW        = 17;
  localparam int SqW       = 47;           // square root remainder and root
  localparam int SqCells   = 23;           // one root bit per cell
  localparam int CordCells = 28;           // one rotation per cell
  localparam int CW        = 58;           // CORDIC vector width
  localparam int AngW      = 33;           // signed angle accumulator
  localparam int UScaled   = 256 * 256;    // U_SIZE in Q8.8
  localparam int VScaled   = 512 * 256;    // V_SIZE in Q9.8
  localparam int UTop      = (2 * 256 - 1) * 256;
  localparam logic [RadiusW-1:0] RadiusReset = 23'd25600;
  localparam logic signed [AngW-1:0] TurnQ = 33'sd1073741824;
  localparam logic [AngW-1:0] TurnH = 33'd2147483648;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic                     last_vertex;
  } in_beat_t;

  typedef struct packed {
    logic [UW-1:0] u_coord;
    logic [VW-1:0] v_coord;
    logic          last_out;
  } out_beat_t;

  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [SqW-1:0]           rem;
    logic [SqW-1:0]           root;
  } sq_beat_t;

  typedef struct packed {
    logic signed [CW-1:0]   cx;
    logic signed [CW-1:0]   cy;
    logic signed [AngW-1:0] ang;
    logic                   zero_a;
    logic                   zero_b;
    logic                   neg_a;
    logic                   neg_b;
  } lane_t;

  typedef struct packed {
    logic  valid;
    logic  last;
    lane_t theta;
    lane_t phi;
  } cord_beat_t;

  function automatic logic signed [AngW-1:0] atan_entry(input logic [4:0] i);
    logic signed [AngW-1:0] t;
    case (i)
      5'd0:  t = 33'sd536870912;
      5'd1:  t = 33'sd316933406;
      5'd2:  t = 33'sd167458907;
      5'd3:  t = 33'sd85004756;
      5'd4:  t = 33'sd42667331;
      5'd5:  t = 33'sd21354465;
      5'd6:  t = 33'sd10679838;
      5'd7:  t = 33'sd5340245;
      5'd8:  t = 33'sd2670163;
      5'd9:  t = 33'sd1335087;
      5'd10: t = 33'sd667544;
      5'd11: t = 33'sd333772;
      5'd12: t = 33'sd166886;
      5'd13: t = 33'sd83443;
      5'd14: t = 33'sd41722;
      5'd15: t = 33'sd20861;
      5'd16: t = 33'sd10430;
      5'd17: t = 33'sd5215;
      5'd18: t = 33'sd2608;
      5'd19: t = 33'sd1304;
      5'd20: t = 33'sd652;
      5'd21: t = 33'sd326;
      5'd22: t = 33'sd163;
      5'd23: t = 33'sd81;
      5'd24: t = 33'sd41;
      5'd25: t = 33'sd20;
      5'd26: t = 33'sd10;
      5'd27: t = 33'sd5;
      default: t = '0;
    endcase
    return t;
  endfunction

  // One restoring square root step; cell k tests bit 4^(SqCells-1-k).
  function automatic sq_beat_t sqrt_step(input sq_beat_t b, input logic [4:0] k);
    sq_beat_t o;
    logic [SqW-1:0] bitv;
    logic [SqW-1:0] trial;
    o = b;
    bitv = SqW'(1) << (2 * (SqCells - 1 - int'(k)));
    trial = b.root + bitv;
    if (b.rem >= trial) begin
      o.rem  = b.rem - trial;
      o.root = (b.root >> 1) + bitv;
    end else begin
      o.root = b.root >> 1;
    end
    return o;
  endfunction

  function automatic lane_t lane_init(input logic signed [CoordW:0] a,
                                      input logic signed [CoordW:0] b);
    lane_t l;
    logic [CoordW:0] ax;
    logic [CoordW:0] ay;
    ax = a[CoordW] ? -a : a;
    ay = b[CoordW] ? -b : b;
    l.cx = CW'(ax) << 32;
    l.cy = CW'(ay) << 32;
    l.ang = '0;
    l.zero_a = (ax == '0);
    l.zero_b = (ay == '0);
    l.neg_a = a[CoordW];
    l.neg_b = b[CoordW];
    return l;
  endfunction

  function automatic lane_t cordic_step(input lane_t l, input logic [4:0] i);
    lane_t o;
    o = l;
    if (!l.cy[CW-1]) begin
      o.cx  = l.cx + (l.cy >>> i);
      o.cy  = l.cy - (l.cx >>> i);
      o.ang = l.ang + atan_entry(i);
    end else begin
      o.cx  = l.cx - (l.cy >>> i);
      o.cy  = l.cy + (l.cx >>> i);
      o.ang = l.ang - atan_entry(i);
    end
    return o;
  endfunction

  // Clamp to a quarter turn, then move into the quadrant of (a, b).
  function automatic logic [31:0] angle_final(input lane_t l);
    logic signed [AngW-1:0] a;
    logic [AngW-1:0] t;
    if (l.zero_b) a = '0;
    else if (l.zero_a) a = TurnQ;
    else if (l.ang[AngW-1]) a = '0;
    else if (l.ang > TurnQ) a = TurnQ;
    else a = l.ang;
    if (!l.neg_a && !l.neg_b) t = a;
    else if (l.neg_a && !l.neg_b) t = TurnH - a;
    else if (l.neg_a) t = TurnH + a;
    else t = -a;
    if (l.zero_a && l.zero_b) t = '0;
    return t[31:0];
  endfunction

endpackage

### design/sphere_to_uv_map_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_to_uv_map_core
// Maps a vertex on a sphere to its polar (u) and azimuth (v) grid coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries one vertex per beat
//   (pos_x, pos_y, pos_z in signed Q16.8 and the last_vertex tag).
//   Output channel out_valid / out_stall / out_data returns one beat per
//   vertex, in order: u_coord (Q8.8), v_coord (Q9.8), last_out.
//   cfg_wr_en / cfg_wr_data write the sphere radius (unsigned Q15.8); write
//   it only while the pipeline is empty.
// Throughput: one vertex per cycle unless the output stalls. The chain of 23
//   square root cells and 28 CORDIC cells each hold one vertex, so a new beat
//   enters every cycle that the chain is not stalled. Pipeline: 55 register
//   stages: input register, two multiply/subtract stages, 23 root cells,
//   28 rotation cells, output.
// Reset: rst clears every valid bit and loads the radius with 100.0.
// Stall: while out_valid is high and out_stall is asserted the whole chain
//   holds and in_stall is raised; the waiting result stays unchanged.
// ----------------------------------------------------------------------------
module sphere_to_uv_map_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  s2uv_pkg::in_beat_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output s2uv_pkg::out_beat_t                  out_data,
  input  logic                                 cfg_wr_en,
  input  logic [s2uv_pkg::RadiusW-1:0]         cfg_wr_data
);

  logic [s2uv_pkg::RadiusW-1:0] radius;
  logic                         adv;

  // Front stages: capture, square, subtract.
  logic                                 v0, v1, v2;
  s2uv_pkg::in_beat_t                   beat0, beat1, beat2;
  logic [s2uv_pkg::RadiusW-1:0]         rad0;
  logic [2*s2uv_pkg::RadiusW-1:0]       rr1;
  logic [2*s2uv_pkg::CoordW-1:0]        zz1;
  logic [s2uv_pkg::SqW-1:0]             d2;
  logic [s2uv_pkg::CoordW-1:0]          zabs0;
  logic signed [s2uv_pkg::SqW:0]        diff1;

  s2uv_pkg::sq_beat_t   sq_chain [s2uv_pkg::SqCells+1];
  s2uv_pkg::cord_beat_t cd_chain [s2uv_pkg::CordCells+1];

  logic [31:0]  theta_ang, phi_ang;
  logic [32:0]  v_sum, u_sum;
  logic [17:0]  v_raw, u_raw;
  logic [17:0]  v_fix, u_fix;
  logic [s2uv_pkg::CoordW:0] phi_b;

  // Advance the whole chain unless a finished result is held by the receiver.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= s2uv_pkg::RadiusReset;
    end else if (cfg_wr_en) begin
      radius <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  assign zabs0 = beat0.pos_z[s2uv_pkg::CoordW-1] ? -beat0.pos_z : beat0.pos_z;
  // z*z never exceeds 2^46, so its top bit is always clear.
  assign diff1 = $signed({2'b00, rr1}) - $signed(zz1);

  always_ff @(posedge clk) begin
    if (adv) begin
      beat0 <= in_data;
      rad0  <= radius;
      // Square radius and z; one multiplier each.
      beat1 <= beat0;
      rr1   <= rad0 * rad0;
      zz1   <= zabs0 * zabs0;
      // Clamp r*r - z*z at zero.
      beat2 <= beat1;
      d2    <= diff1[s2uv_pkg::SqW] ? '0 : diff1[s2uv_pkg::SqW-1:0];
    end
  end

  always_comb begin
    sq_chain[0].valid = v2;
    sq_chain[0].last  = beat2.last_vertex;
    sq_chain[0].x     = beat2.pos_x;
    sq_chain[0].y     = beat2.pos_y;
    sq_chain[0].z     = beat2.pos_z;
    sq_chain[0].rem   = d2;
    sq_chain[0].root  = '0;
  end

  for (genvar k = 0; k < s2uv_pkg::SqCells; k++) begin : g_sqrt
    s2uv_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .idx  (5'(k)),
      .din  (sq_chain[k]),
      .dout (sq_chain[k+1])
    );
  end

  // Seed both angle lanes: theta = atan2(y, x), phi = atan2(s, z).
  assign phi_b = {2'b00, sq_chain[s2uv_pkg::SqCells].root[s2uv_pkg::CoordW-2:0]};

  always_comb begin
    cd_chain[0].valid = sq_chain[s2uv_pkg::SqCells].valid;
    cd_chain[0].last  = sq_chain[s2uv_pkg::SqCells].last;
    cd_chain[0].theta = s2uv_pkg::lane_init(
                          {sq_chain[s2uv_pkg::SqCells].x[s2uv_pkg::CoordW-1],
                           sq_chain[s2uv_pkg::SqCells].x},
                          {sq_chain[s2uv_pkg::SqCells].y[s2uv_pkg::CoordW-1],
                           sq_chain[s2uv_pkg::SqCells].y});
    cd_chain[0].phi   = s2uv_pkg::lane_init(
                          {sq_chain[s2uv_pkg::SqCells].z[s2uv_pkg::CoordW-1],
                           sq_chain[s2uv_pkg::SqCells].z},
                          phi_b);
  end

  for (genvar k = 0; k < s2uv_pkg::CordCells; k++) begin : g_cordic
    s2uv_cordic_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .idx  (5'(k)),
      .din  (cd_chain[k]),
      .dout (cd_chain[k+1])
    );
  end

  // Scale angles: a full turn maps to V_SIZE*256, a half turn to U_SIZE*256.
  assign theta_ang = s2uv_pkg::angle_final(cd_chain[s2uv_pkg::CordCells].theta);
  assign phi_ang   = s2uv_pkg::angle_final(cd_chain[s2uv_pkg::CordCells].phi);
  assign v_sum     = {1'b0, theta_ang} + 33'd16384;
  assign u_sum     = {1'b0, phi_ang} + 33'd16384;
  assign v_raw     = v_sum[32:15];
  assign u_raw     = u_sum[32:15];

  always_comb begin
    // Wrap v at a full turn; mirror u past the pole.
    v_fix = (v_raw >= 18'(s2uv_pkg::VScaled)) ? v_raw - 18'(s2uv_pkg::VScaled) : v_raw;
    if (u_raw >= 18'(s2uv_pkg::UScaled)) begin
      u_fix = (u_raw <= 18'(s2uv_pkg::UTop)) ? 18'(s2uv_pkg::UTop) - u_raw : '0;
    end else begin
      u_fix = u_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= cd_chain[s2uv_pkg::CordCells].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.u_coord  <= u_fix[s2uv_pkg::UW-1:0];
      out_data.v_coord  <= v_fix[s2uv_pkg::VW-1:0];
      out_data.last_out <= cd_chain[s2uv_pkg::CordCells].last;
    end
  end

endmodule

### design/s2uv_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2uv_sqrt_cell
// One stage of the square root chain: settles one root bit per cycle while en is high.
// ----------------------------------------------------------------------------
module s2uv_sqrt_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [4:0]         idx,
  input  s2uv_pkg::sq_beat_t din,
  output s2uv_pkg::sq_beat_t dout
);

  s2uv_pkg::sq_beat_t stage_next;

  assign stage_next = s2uv_pkg::sqrt_step(din, idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (en) begin
      dout.last <= stage_next.last;
      dout.x    <= stage_next.x;
      dout.y    <= stage_next.y;
      dout.z    <= stage_next.z;
      dout.rem  <= stage_next.rem;
      dout.root <= stage_next.root;
    end
  end

endmodule

### design/s2uv_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2uv_cordic_cell
// One CORDIC vectoring rotation for both the azimuth and the polar lane.
// ----------------------------------------------------------------------------
module s2uv_cordic_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [4:0]           idx,
  input  s2uv_pkg::cord_beat_t din,
  output s2uv_pkg::cord_beat_t dout
);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.last  <= din.last;
      dout.theta <= s2uv_pkg::cordic_step(din.theta, idx);
      dout.phi   <= s2uv_pkg::cordic_step(din.phi, idx);
    end
  end

endmodule

### design/s2uv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2uv_checker
// Port-level checks on the sphere to UV mapping core.
// ----------------------------------------------------------------------------
`include "sphere_to_uv_map_core_assert.svh"

module s2uv_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input s2uv_pkg::in_beat_t           in_data,
  input logic                         out_valid,
  input logic                         out_stall,
  input s2uv_pkg::out_beat_t          out_data,
  input logic                         cfg_wr_en,
  input logic [s2uv_pkg::RadiusW-1:0] cfg_wr_data
);

  logic unused_ok;
  assign unused_ok = ^{in_valid, in_data, cfg_wr_en, cfg_wr_data};

  // Hold a stalled result beat.
  `S2UV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped under stall")
  `S2UV_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled result changed")
  // Stall the input only while a result is held back.
  `S2UV_ASSERT_NOW(a_in_stall, in_stall, out_valid && out_stall, "input stalled without cause")
  // Drop all results on reset.
  `S2UV_ASSERT_ALWAYS(a_reset, $past(rst), !out_valid, "result beat right after reset")

endmodule

bind sphere_to_uv_map_core s2uv_checker u_s2uv_checker (.*);
